[hw/rtl/ssrg_pkg.sv]
// shared types, constants and lookup functions of the seven-segment rectangle generator
`default_nettype none

package ssrg_pkg;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [4:0]  LAST_ELEM     = 5'd29;
  localparam logic [1:0]  SETTLE_CYCLES = 2'd3;
  localparam logic [1:0]  LAST_DIGIT    = 2'd3;

  // x / 50 as (x * DIV50_MULT) >> DIV50_SHIFT, exact for x < 2^19
  localparam logic [19:0] DIV50_MULT  = 20'd671089;
  localparam int unsigned DIV50_SHIFT = 25;

  // x / 10 as (x * DIV10_MULT) >> 19, exact for any 16-bit x
  localparam logic [15:0] DIV10_MULT  = 16'd52429;

  typedef logic [15:0] coord_t;
  typedef logic [31:0] color_t;
  typedef logic [6:0]  seg_map_t;

  typedef enum logic [2:0] {
    CFG_BOX_LEFT   = 3'd0,
    CFG_BOX_TOP    = 3'd1,
    CFG_BOX_WIDTH  = 3'd2,
    CFG_BOX_HEIGHT = 3'd3,
    CFG_SHIFT_X    = 3'd4,
    CFG_SHIFT_Y    = 3'd5,
    CFG_LIT_COLOR  = 3'd6,
    CFG_DARK_COLOR = 3'd7
  } cfg_reg_t;

  // segments in emission order
  typedef enum logic [2:0] {
    SEG_TOP         = 3'd0,
    SEG_BOTTOM      = 3'd1,
    SEG_UPPER_LEFT  = 3'd2,
    SEG_LOWER_LEFT  = 3'd3,
    SEG_UPPER_RIGHT = 3'd4,
    SEG_LOWER_RIGHT = 3'd5,
    SEG_MIDDLE      = 3'd6
  } seg_t;

  typedef struct packed {
    coord_t box_left;
    coord_t box_top;
    coord_t box_width;
    coord_t box_height;
    coord_t shift_x;
    coord_t shift_y;
  } geom_cfg_t;

  // ox is indexed by digit position, units first
  typedef struct packed {
    coord_t [NUM_DIGITS-1:0] ox;
    coord_t x_bar_l;
    coord_t x_bar_r;
    coord_t x_left_r;
    coord_t x_right_l;
    coord_t x_right_r;
    coord_t colon_l;
    coord_t colon_r;
    coord_t y0;
    coord_t y_h8;
    coord_t y_3h8;
    coord_t y_5h8;
    coord_t y_7h8;
    coord_t y_half;
    coord_t y_low;
    coord_t y_7h16;
    coord_t y_9h16;
  } geom_t;

  // one queued run: colon flag and the segment maps, units digit first
  typedef struct packed {
    logic                      colon;
    seg_map_t [NUM_DIGITS-1:0] maps;
  } run_t;

  function automatic seg_map_t digit_map(input logic [3:0] digit);
    seg_map_t m;
    unique case (digit)
      4'd0:    m = 7'h3F;
      4'd1:    m = 7'h06;
      4'd2:    m = 7'h5B;
      4'd3:    m = 7'h4F;
      4'd4:    m = 7'h66;
      4'd5:    m = 7'h6D;
      4'd6:    m = 7'h7D;
      4'd7:    m = 7'h07;
      4'd8:    m = 7'h7F;
      4'd9:    m = 7'h67;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

  // bit of the segment map that drives a segment
  function automatic logic [2:0] map_bit(input seg_t seg);
    logic [2:0] b;
    unique case (seg)
      SEG_TOP:         b = 3'd0;
      SEG_BOTTOM:      b = 3'd3;
      SEG_UPPER_LEFT:  b = 3'd5;
      SEG_LOWER_LEFT:  b = 3'd4;
      SEG_UPPER_RIGHT: b = 3'd1;
      SEG_LOWER_RIGHT: b = 3'd2;
      SEG_MIDDLE:      b = 3'd6;
      default:         b = 3'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ssrg_geom.sv]
// geometry pipeline: box registers to rectangle edges, three register stages
`default_nettype none

module ssrg_geom (
  input  wire logic               clk,
  input  ssrg_pkg::geom_cfg_t     cfg,
  output ssrg_pkg::geom_t         geom
);
  import ssrg_pkg::*;

  logic [18:0] scaled;
  logic [38:0] prod_r;
  coord_t      y0_r;
  coord_t      base_r;

  logic [12:0] extra;
  logic [11:0] sp;
  coord_t      dw;
  logic [17:0] h3;
  logic [18:0] h5;
  logic [18:0] h7;
  logic [19:0] h9;

  logic [12:0] extra_r;
  logic [11:0] sp_r;
  coord_t      dw_r;
  coord_t      base2_r;

  coord_t      pitch;
  coord_t      pitch2;
  coord_t      pitch3;
  logic [18:0] dw7;
  coord_t      dw7_8;
  geom_t       geom_r;

  // stage 1: 5w + 50 times reciprocal of 50
  assign scaled = {1'b0, cfg.box_width, 2'b00} + {3'b000, cfg.box_width} + 19'd50;

  always_ff @(posedge clk) begin
    prod_r <= {20'b0, scaled} * {19'b0, DIV50_MULT};
    y0_r   <= cfg.box_top + cfg.shift_y;
    base_r <= cfg.box_left + cfg.shift_x;
  end

  // stage 2: spacing, digit width and vertical edges
  assign extra = prod_r[DIV50_SHIFT+12:DIV50_SHIFT];
  assign sp    = extra[12:1];
  assign dw    = {2'b00, cfg.box_width[15:2]} - {4'b0000, sp} - {6'b000000, sp[11:2]};
  assign h3    = {1'b0, cfg.box_height, 1'b0} + {2'b00, cfg.box_height};
  assign h5    = {1'b0, cfg.box_height, 2'b00} + {3'b000, cfg.box_height};
  assign h7    = {cfg.box_height, 3'b000} - {3'b000, cfg.box_height};
  assign h9    = {1'b0, cfg.box_height, 3'b000} + {4'b0000, cfg.box_height};

  always_ff @(posedge clk) begin
    extra_r       <= extra;
    sp_r          <= sp;
    dw_r          <= dw;
    base2_r       <= base_r;
    geom_r.y0     <= y0_r;
    geom_r.y_h8   <= y0_r + {3'b000, cfg.box_height[15:3]};
    geom_r.y_3h8  <= y0_r + {1'b0, h3[17:3]};
    geom_r.y_5h8  <= y0_r + h5[18:3];
    geom_r.y_7h8  <= y0_r + h7[18:3];
    geom_r.y_half <= y0_r + {1'b0, cfg.box_height[15:1]};
    geom_r.y_low  <= y0_r + cfg.box_height - 16'd1;
    geom_r.y_7h16 <= y0_r + {1'b0, h7[18:4]};
    geom_r.y_9h16 <= y0_r + h9[19:4];
  end

  // stage 3: digit origins and horizontal offsets
  assign pitch  = dw_r + {4'b0000, sp_r};
  assign pitch2 = {pitch[14:0], 1'b0};
  assign pitch3 = pitch2 + pitch;
  assign dw7    = {dw_r, 3'b000} - {3'b000, dw_r};
  assign dw7_8  = dw7[18:3];

  always_ff @(posedge clk) begin
    geom_r.ox[0]     <= base2_r + pitch3 + {3'b000, extra_r};
    geom_r.ox[1]     <= base2_r + pitch2 + {3'b000, extra_r};
    geom_r.ox[2]     <= base2_r + pitch;
    geom_r.ox[3]     <= base2_r;
    geom_r.x_bar_l   <= {3'b000, dw_r[15:3]} + 16'd1;
    geom_r.x_bar_r   <= dw7_8 - 16'd1;
    geom_r.x_left_r  <= {3'b000, dw_r[15:3]};
    geom_r.x_right_l <= dw7_8;
    geom_r.x_right_r <= dw_r - 16'd1;
    geom_r.colon_l   <= base2_r + pitch2;
    geom_r.colon_r   <= base2_r + pitch2 + {4'b0000, sp_r} - 16'd1;
  end

  assign geom = geom_r;

endmodule

`default_nettype wire

[hw/rtl/ssrg_front.sv]
// front end: takes a value and splits it into four segment maps, one digit a cycle
`default_nettype none

module ssrg_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic [15:0]     value,
  input  wire logic            colon,
  input  wire logic            q_ready,
  output logic                 push,
  output ssrg_pkg::run_t       push_data,
  output logic                 front_busy
);
  import ssrg_pkg::*;

  logic                      have_r;
  logic                      done_r;
  logic [1:0]                cnt_r;
  logic [15:0]               val_r;
  logic                      colon_r;
  seg_map_t [NUM_DIGITS-1:0] maps_r;

  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot10;
  logic [15:0] rem;

  // divide by ten through the reciprocal
  assign prod   = {16'b0, val_r} * {16'b0, DIV10_MULT};
  assign quot   = prod[31:19];
  assign quot10 = {quot[12:0], 3'b000} + {2'b00, quot[12:0], 1'b0};
  assign rem    = val_r - quot10;

  assign push       = have_r && done_r;
  assign front_busy = have_r && !(done_r && q_ready);

  assign push_data.colon = colon_r;
  assign push_data.maps  = maps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (load) begin
      have_r  <= 1'b1;
      done_r  <= 1'b0;
      cnt_r   <= 2'd0;
      val_r   <= value;
      colon_r <= colon;
    end else if (have_r && !done_r) begin
      maps_r[cnt_r] <= digit_map(rem[3:0]);
      val_r         <= {3'b000, quot};
      cnt_r         <= cnt_r + 2'd1;
      done_r        <= (cnt_r == LAST_DIGIT);
    end else if (push && q_ready) begin
      have_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ssrg_queue.sv]
// two-entry queue of decoded runs between front and back end
`default_nettype none

module ssrg_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  ssrg_pkg::run_t     push_data,
  output logic               q_ready,
  input  wire logic          pop,
  output logic               q_valid,
  output ssrg_pkg::run_t     q_data
);
  import ssrg_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  run_t             mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign q_ready = (count_r != CNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;
  assign q_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ssrg_back.sv]
// back end: walks a run and emits one registered rectangle a cycle
`default_nettype none

module ssrg_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  ssrg_pkg::geom_t         geom,
  input  ssrg_pkg::color_t        lit_color,
  input  ssrg_pkg::color_t        dark_color,
  input  wire logic               q_valid,
  input  ssrg_pkg::run_t          q_data,
  output logic                    pop,
  output logic                    out_strobe,
  output logic [15:0]             out_rect_left,
  output logic [15:0]             out_rect_right,
  output logic [15:0]             out_rect_top,
  output logic [15:0]             out_rect_bottom,
  output logic [31:0]             out_fill_color,
  output logic [4:0]              out_element_index,
  output logic                    out_last_rect
);
  import ssrg_pkg::*;

  logic       active_r;
  logic [4:0] elem_r;
  logic [1:0] dig_r;
  seg_t       seg_r;
  run_t       cur_r;

  logic       is_last;
  logic       is_colon;
  logic       lit;
  coord_t     ox;
  coord_t     left_nxt;
  coord_t     right_nxt;
  coord_t     top_nxt;
  coord_t     bottom_nxt;
  color_t     color_nxt;

  logic       strobe_r;
  coord_t     left_r;
  coord_t     right_r;
  coord_t     top_r;
  coord_t     bottom_r;
  color_t     color_r;
  logic [4:0] index_r;
  logic       last_r;

  assign is_last  = (elem_r == LAST_ELEM);
  assign is_colon = (elem_r[4:1] == 4'd0);
  assign pop      = q_valid && (!active_r || is_last);
  assign ox       = geom.ox[dig_r];
  assign lit      = cur_r.maps[dig_r][map_bit(seg_r)];

  always_comb begin
    if (is_colon) begin
      left_nxt   = geom.colon_l;
      right_nxt  = geom.colon_r;
      top_nxt    = elem_r[0] ? geom.y_5h8 : geom.y_h8;
      bottom_nxt = elem_r[0] ? geom.y_7h8 : geom.y_3h8;
      color_nxt  = cur_r.colon ? lit_color : dark_color;
    end else begin
      color_nxt = lit ? lit_color : dark_color;
      unique case (seg_r)
        SEG_TOP: begin
          left_nxt   = ox + geom.x_bar_l;
          right_nxt  = ox + geom.x_bar_r;
          top_nxt    = geom.y0;
          bottom_nxt = geom.y_h8;
        end
        SEG_BOTTOM: begin
          left_nxt   = ox + geom.x_bar_l;
          right_nxt  = ox + geom.x_bar_r;
          top_nxt    = geom.y_7h8;
          bottom_nxt = geom.y_low;
        end
        SEG_UPPER_LEFT: begin
          left_nxt   = ox;
          right_nxt  = ox + geom.x_left_r;
          top_nxt    = geom.y0;
          bottom_nxt = geom.y_half;
        end
        SEG_LOWER_LEFT: begin
          left_nxt   = ox;
          right_nxt  = ox + geom.x_left_r;
          top_nxt    = geom.y_half;
          bottom_nxt = geom.y_low;
        end
        SEG_UPPER_RIGHT: begin
          left_nxt   = ox + geom.x_right_l;
          right_nxt  = ox + geom.x_right_r;
          top_nxt    = geom.y0;
          bottom_nxt = geom.y_half;
        end
        SEG_LOWER_RIGHT: begin
          left_nxt   = ox + geom.x_right_l;
          right_nxt  = ox + geom.x_right_r;
          top_nxt    = geom.y_half;
          bottom_nxt = geom.y_low;
        end
        default: begin
          left_nxt   = ox + geom.x_bar_l;
          right_nxt  = ox + geom.x_bar_r;
          top_nxt    = geom.y_7h16;
          bottom_nxt = geom.y_9h16;
        end
      endcase
    end
  end

  // run sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      elem_r   <= 5'd0;
      dig_r    <= 2'd0;
      seg_r    <= SEG_TOP;
    end else if (pop) begin
      active_r <= 1'b1;
      elem_r   <= 5'd0;
      dig_r    <= 2'd0;
      seg_r    <= SEG_TOP;
      cur_r    <= q_data;
    end else if (active_r) begin
      if (is_last) begin
        active_r <= 1'b0;
      end else begin
        elem_r <= elem_r + 5'd1;
      end
      if (!is_colon) begin
        if (seg_r == SEG_MIDDLE) begin
          seg_r <= SEG_TOP;
          dig_r <= dig_r + 2'd1;
        end else begin
          seg_r <= seg_t'(seg_r + 3'd1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    top_r    <= top_nxt;
    bottom_r <= bottom_nxt;
    color_r  <= color_nxt;
    index_r  <= elem_r;
    last_r   <= is_last;
  end

  assign out_strobe        = strobe_r;
  assign out_rect_left     = left_r;
  assign out_rect_right    = right_r;
  assign out_rect_top      = top_r;
  assign out_rect_bottom   = bottom_r;
  assign out_fill_color    = color_r;
  assign out_element_index = index_r;
  assign out_last_rect     = last_r;

endmodule

`default_nettype wire

[hw/rtl/seven_segment_rectangle_generator.sv]
// top level of the seven-segment rectangle generator: config registers, front, queue, back
// a value passes the digit split, the queue and the back end's run and output registers
// 30 rectangles per value, one a cycle while a run is drawn; the back end sets the pace
// and the front end splits the next value ahead of it
// reset and every config write hold busy while the geometry pipeline settles
// results go out on a one-cycle strobe and cannot be held off by the receiver
`default_nettype none

module seven_segment_rectangle_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transaction
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_shown_value,
  input  wire logic        in_colon_on,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // result transaction
  output logic             out_strobe,
  output logic [15:0]      out_rect_left,
  output logic [15:0]      out_rect_right,
  output logic [15:0]      out_rect_top,
  output logic [15:0]      out_rect_bottom,
  output logic [31:0]      out_fill_color,
  output logic [4:0]       out_element_index,
  output logic             out_last_rect
);
  import ssrg_pkg::*;

  // configuration registers
  geom_cfg_t  cfg_r;
  color_t     lit_color_r;
  color_t     dark_color_r;
  logic [1:0] settle_r;

  // front to queue to back
  logic   accept;
  logic   front_busy;
  logic   push;
  run_t   push_data;
  logic   q_ready;
  logic   q_valid;
  run_t   q_data;
  logic   pop;
  geom_t  geom;

  // the config port never stalls
  assign cfg_ready = 1'b1;

  // a new value is taken while the back end is still drawing the previous run;
  // a front end still splitting a value or with a run stuck behind a full queue,
  // or settling geometry, holds it off
  assign busy   = front_busy || (settle_r != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_left   <= 16'd0;
      cfg_r.box_top    <= 16'd0;
      cfg_r.box_width  <= 16'd128;
      cfg_r.box_height <= 16'd32;
      cfg_r.shift_x    <= 16'd0;
      cfg_r.shift_y    <= 16'd0;
      lit_color_r      <= 32'd0;
      dark_color_r     <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BOX_LEFT:   cfg_r.box_left   <= cfg_data[15:0];
        CFG_BOX_TOP:    cfg_r.box_top    <= cfg_data[15:0];
        CFG_BOX_WIDTH:  cfg_r.box_width  <= cfg_data[15:0];
        CFG_BOX_HEIGHT: cfg_r.box_height <= cfg_data[15:0];
        CFG_SHIFT_X:    cfg_r.shift_x    <= cfg_data[15:0];
        CFG_SHIFT_Y:    cfg_r.shift_y    <= cfg_data[15:0];
        CFG_LIT_COLOR:  lit_color_r      <= cfg_data;
        CFG_DARK_COLOR: dark_color_r     <= cfg_data;
      endcase
    end
  end

  // geometry is three register stages behind the config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else if (cfg_valid && cfg_ready) begin
      settle_r <= SETTLE_CYCLES;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  ssrg_geom u_geom (
    .clk  (clk),
    .cfg  (cfg_r),
    .geom (geom)
  );

  // front end: decimal split into segment maps
  ssrg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .value      (in_shown_value),
    .colon      (in_colon_on),
    .q_ready    (q_ready),
    .push       (push),
    .push_data  (push_data),
    .front_busy (front_busy)
  );

  // decouples the decode from the drawing
  ssrg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // back end: 2 colon bars then 4 digits of 7 segments, units digit first
  ssrg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .geom              (geom),
    .lit_color         (lit_color_r),
    .dark_color        (dark_color_r),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .pop               (pop),
    .out_strobe        (out_strobe),
    .out_rect_left     (out_rect_left),
    .out_rect_right    (out_rect_right),
    .out_rect_top      (out_rect_top),
    .out_rect_bottom   (out_rect_bottom),
    .out_fill_color    (out_fill_color),
    .out_element_index (out_element_index),
    .out_last_rect     (out_last_rect)
  );

`ifndef SYNTHESIS
  // the last flag marks the final rectangle of a run and nothing else
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_rect |-> out_element_index == LAST_ELEM)
    else $error("last rectangle flag on wrong element");

  // a run is emitted without gaps
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_element_index != 5'd0) |-> $past(out_strobe))
    else $error("gap inside a rectangle run");

  // no new value while the geometry is catching up with a config write
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> busy)
    else $error("input taken right after a config write");

  // a run offered to a full queue stays held in the front end
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_ready |-> front_busy)
    else $error("front end released a run the queue could not take");
`endif

endmodule

`default_nettype wire
